// ===== rtl/pbpc_pkg.sv =====
package pbpc_pkg;

  // field widths of the two channels
  localparam int SAMPLE_W    = 12;
  localparam int BASE_SUM_W  = 22;
  localparam int MIN_ADC_W   = 12;
  localparam int MIN_INDEX_W = 10;
  localparam int WIN_SUM_W   = 22;
  localparam int WIN_LEN_W   = 11;
  localparam int CHARGE_W    = 33;

  // configuration registers
  localparam int BC_W        = 11;
  localparam int PRE_W       = 10;
  localparam int POST_W      = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [BC_W-1:0]   BC_RESET   = BC_W'(16 * 8);
  localparam logic [PRE_W-1:0]  PRE_RESET  = PRE_W'(16 * 4);
  localparam logic [POST_W-1:0] POST_RESET = POST_W'(16 * 36);

  // default sizing
  localparam int WAVE_SAMPLES_DEF = 1024;
  localparam int ADC_BITS_DEF     = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASELINE_COUNT = 2'd0,
    REG_PRE_WINDOW     = 2'd1,
    REG_POST_WINDOW    = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/pbpc_sample_if.sv =====
interface pbpc_sample_if;
  import pbpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/pbpc_result_if.sv =====
interface pbpc_result_if;
  import pbpc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BASE_SUM_W-1:0]  baseline_sum;
  logic [MIN_ADC_W-1:0]   min_adc;
  logic [MIN_INDEX_W-1:0] min_index;
  logic [WIN_SUM_W-1:0]   window_sum;
  logic [WIN_LEN_W-1:0]   window_length;
  logic signed [CHARGE_W-1:0] charge_scaled;

  modport source (
    output valid, output baseline_sum, output min_adc, output min_index,
    output window_sum, output window_length, output charge_scaled,
    input ready
  );
  modport sink (
    input valid, input baseline_sum, input min_adc, input min_index,
    input window_sum, input window_length, input charge_scaled,
    output ready
  );
endinterface

// ===== rtl/pulse_baseline_peak_charge.sv =====
// channel   dir  payload                                          handshake
// samples   in   sample                                           valid/ready
// results   out  baseline_sum min_adc min_index window_sum        valid/ready
//                window_length charge_scaled
// cfg       in   cfg_index cfg_data                               cfg_write
//
// one sample per cycle while a waveform is collected into the sample memory
// after the last sample, samples stall until the result is registered: the window
// is reread from the memory one entry per cycle, then two multiply/subtract steps
// the next waveform is taken while a result waits; its end waits for the output
// synchronous reset clears control and restores the register defaults
module pulse_baseline_peak_charge #(
  parameter int WAVE_SAMPLES = pbpc_pkg::WAVE_SAMPLES_DEF,
  parameter int ADC_BITS     = pbpc_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pbpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  pbpc_sample_if.sink                      samples,
  pbpc_result_if.source                    results
);
  import pbpc_pkg::*;

  localparam int PW   = $clog2(WAVE_SAMPLES);
  localparam int CNTW = $clog2(WAVE_SAMPLES + 1);
  localparam int ACCW = ADC_BITS + PW;

  logic [BC_W-1:0]   baseline_count;
  logic [PRE_W-1:0]  pre_window;
  logic [POST_W-1:0] post_window;
  logic [CNTW-1:0]   bc;

  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic [ADC_BITS-1:0] wr_data;
  logic [PW-1:0]       rd_addr;
  logic [ADC_BITS-1:0] rd_data;
  logic [ACCW-1:0]     acc;
  logic [ADC_BITS:0]   min_val;
  logic [PW-1:0]       min_pos;
  logic                wave_done;
  logic                rearm;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_count <= BC_RESET;
      pre_window     <= PRE_RESET;
      post_window    <= POST_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASELINE_COUNT: baseline_count <= cfg_data[BC_W-1:0];
        REG_PRE_WINDOW:     pre_window     <= cfg_data[PRE_W-1:0];
        REG_POST_WINDOW:    post_window    <= cfg_data[POST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // baseline count saturates at the waveform length
  always_comb begin
    if (32'(baseline_count) > 32'(WAVE_SAMPLES)) begin
      bc = CNTW'(WAVE_SAMPLES);
    end else begin
      bc = CNTW'(baseline_count);
    end
  end

  pbpc_ram #(
    .WIDTH (ADC_BITS),
    .DEPTH (WAVE_SAMPLES)
  ) u_wave_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pbpc_capture #(
    .WAVE_SAMPLES (WAVE_SAMPLES),
    .ADC_BITS     (ADC_BITS)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .bc        (bc),
    .rearm     (rearm),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .acc       (acc),
    .min_val   (min_val),
    .min_pos   (min_pos),
    .wave_done (wave_done)
  );

  pbpc_window #(
    .WAVE_SAMPLES (WAVE_SAMPLES),
    .ADC_BITS     (ADC_BITS)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .wave_done   (wave_done),
    .bc          (bc),
    .pre_window  (pre_window),
    .post_window (post_window),
    .acc         (acc),
    .min_val     (min_val),
    .min_pos     (min_pos),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .rearm       (rearm),
    .results     (results)
  );

endmodule

// ===== rtl/pbpc_ram.sv =====
module pbpc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pbpc_capture.sv =====
module pbpc_capture #(
  parameter int WAVE_SAMPLES = 1024,
  parameter int ADC_BITS     = 12
) (
  input  logic                                          clk,
  input  logic                                          rst,
  pbpc_sample_if.sink                                   samples,
  input  logic [$clog2(WAVE_SAMPLES+1)-1:0]             bc,
  input  logic                                          rearm,
  output logic                                          wr_en,
  output logic [$clog2(WAVE_SAMPLES)-1:0]               wr_addr,
  output logic [ADC_BITS-1:0]                           wr_data,
  output logic [ADC_BITS+$clog2(WAVE_SAMPLES)-1:0]      acc,
  output logic [ADC_BITS:0]                             min_val,
  output logic [$clog2(WAVE_SAMPLES)-1:0]               min_pos,
  output logic                                          wave_done
);
  import pbpc_pkg::*;

  localparam int PW   = $clog2(WAVE_SAMPLES);
  localparam int CNTW = $clog2(WAVE_SAMPLES + 1);
  localparam int ACCW = ADC_BITS + PW;
  localparam logic [PW-1:0]     LAST_POS = PW'(WAVE_SAMPLES - 1);
  localparam logic [ADC_BITS:0] MIN_INIT = {1'b1, {ADC_BITS{1'b0}}};

  logic [PW-1:0]       pos;
  logic                busy;
  logic                accept;
  logic [ADC_BITS-1:0] s;
  logic                last;

  assign samples.ready = !busy;
  assign accept        = samples.valid && !busy;
  assign s             = ADC_BITS'(samples.sample);
  assign last          = (pos == LAST_POS);

  assign wr_en   = accept;
  assign wr_addr = pos;
  assign wr_data = s;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      busy      <= 1'b0;
      wave_done <= 1'b0;
      acc       <= '0;
      min_val   <= MIN_INIT;
      min_pos   <= '0;
    end else begin
      wave_done <= accept && last;
      if (rearm) begin
        // window finished with this waveform, start collecting the next one
        busy    <= 1'b0;
        acc     <= '0;
        min_val <= MIN_INIT;
        min_pos <= '0;
      end else if (accept) begin
        if (CNTW'(pos) < bc) begin
          acc <= acc + ACCW'(s);
        end
        // strict compare keeps the earliest index on ties
        if ({1'b0, s} < min_val) begin
          min_val <= {1'b0, s};
          min_pos <= pos;
        end
        if (last) begin
          pos  <= '0;
          busy <= 1'b1;
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/pbpc_window.sv =====
module pbpc_window #(
  parameter int WAVE_SAMPLES = 1024,
  parameter int ADC_BITS     = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     wave_done,
  input  logic [$clog2(WAVE_SAMPLES+1)-1:0]        bc,
  input  logic [pbpc_pkg::PRE_W-1:0]               pre_window,
  input  logic [pbpc_pkg::POST_W-1:0]              post_window,
  input  logic [ADC_BITS+$clog2(WAVE_SAMPLES)-1:0] acc,
  input  logic [ADC_BITS:0]                        min_val,
  input  logic [$clog2(WAVE_SAMPLES)-1:0]          min_pos,
  output logic [$clog2(WAVE_SAMPLES)-1:0]          rd_addr,
  input  logic [ADC_BITS-1:0]                      rd_data,
  output logic                                     rearm,
  pbpc_result_if.source                            results
);
  import pbpc_pkg::*;

  localparam int PW   = $clog2(WAVE_SAMPLES);
  localparam int CNTW = $clog2(WAVE_SAMPLES + 1);
  localparam int ACCW = ADC_BITS + PW;
  localparam int EW   = $clog2(WAVE_SAMPLES + (1 << POST_W));
  localparam int PRW  = ACCW + CNTW;
  localparam int DW   = (PRW > CHARGE_W) ? PRW : CHARGE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_MUL,
    S_FINISH
  } state_t;

  state_t          state;
  logic [CNTW-1:0] addr;
  logic [CNTW-1:0] stop;
  logic [CNTW-1:0] len;
  logic            rd_pend;
  logic [ACCW-1:0] wsum;
  logic [PRW-1:0]  prod_a;
  logic [PRW-1:0]  prod_b;
  logic [DW-1:0]   diff;

  logic [EW-1:0]   stop_sum;
  logic [PW-1:0]   start_c;
  logic [CNTW-1:0] stop_c;

  logic                       res_valid;
  logic [BASE_SUM_W-1:0]      res_base;
  logic [MIN_ADC_W-1:0]       res_min;
  logic [MIN_INDEX_W-1:0]     res_index;
  logic [WIN_SUM_W-1:0]       res_wsum;
  logic [WIN_LEN_W-1:0]       res_len;
  logic signed [CHARGE_W-1:0] res_charge;

  // window bounds clamped to the waveform
  always_comb begin
    stop_sum = EW'(min_pos) + EW'(post_window);
    if (EW'(min_pos) >= EW'(pre_window)) begin
      start_c = min_pos - PW'(pre_window);
    end else begin
      start_c = '0;
    end
    if (stop_sum > EW'(WAVE_SAMPLES)) begin
      stop_c = CNTW'(WAVE_SAMPLES);
    end else begin
      stop_c = CNTW'(stop_sum);
    end
  end

  assign rd_addr = addr[PW-1:0];
  assign diff    = DW'(prod_a) - DW'(prod_b);

  assign results.valid         = res_valid;
  assign results.baseline_sum  = res_base;
  assign results.min_adc       = res_min;
  assign results.min_index     = res_index;
  assign results.window_sum    = res_wsum;
  assign results.window_length = res_len;
  assign results.charge_scaled = res_charge;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      rearm     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rearm <= (state == S_FINISH) && (!res_valid || results.ready);
      if (results.ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (wave_done) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          addr    <= CNTW'(start_c);
          stop    <= stop_c;
          len     <= stop_c - CNTW'(start_c);
          wsum    <= '0;
          rd_pend <= 1'b0;
          state   <= S_SWEEP;
        end
        S_SWEEP: begin
          // one read issued per cycle, its data added in the cycle after
          rd_pend <= (addr < stop);
          if (rd_pend) begin
            wsum <= wsum + ACCW'(rd_data);
          end
          if (addr < stop) begin
            addr <= addr + CNTW'(1);
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_a <= PRW'(wsum) * PRW'(bc);
          prod_b <= PRW'(len) * PRW'(acc);
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (!res_valid || results.ready) begin
            res_valid  <= 1'b1;
            res_base   <= BASE_SUM_W'(acc);
            res_min    <= MIN_ADC_W'(min_val);
            res_index  <= MIN_INDEX_W'(min_pos);
            res_wsum   <= WIN_SUM_W'(wsum);
            res_len    <= WIN_LEN_W'(len);
            res_charge <= CHARGE_W'(diff);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import pbpc_pkg::*;

  localparam int WAVE_LEN = WAVE_SAMPLES_DEF;

  typedef struct {
    logic [BASE_SUM_W-1:0]      baseline_sum;
    logic [MIN_ADC_W-1:0]       min_adc;
    logic [MIN_INDEX_W-1:0]     min_index;
    logic [WIN_SUM_W-1:0]       window_sum;
    logic [WIN_LEN_W-1:0]       window_length;
    logic signed [CHARGE_W-1:0] charge_scaled;
  } pulse_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pbpc_sample_if smp_if ();
  pbpc_result_if res_if ();

  pulse_baseline_peak_charge i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (smp_if),
    .results   (res_if)
  );

  always #5 clk = ~clk;

  // local copy of the block state
  logic [BC_W-1:0]        base_count;
  logic [PRE_W-1:0]       pre_count;
  logic [POST_W-1:0]      post_count;
  logic [SAMPLE_W-1:0]    wave_mem [WAVE_LEN];
  logic [MIN_INDEX_W-1:0] wave_pos;
  logic [22:0]            base_acc;
  logic [SAMPLE_W:0]      min_val;
  logic [MIN_INDEX_W-1:0] min_pos;

  pulse_result_t       expected_pulses [$];
  logic [SAMPLE_W-1:0] shape [WAVE_LEN];
  int                  mismatches = 0;
  int                  pulses_seen = 0;
  int unsigned         rx_max_gap = 0;
  int unsigned         rx_hold = 0;

  function automatic void start_wave();
    wave_pos = '0;
    base_acc = '0;
    min_val  = {1'b1, {SAMPLE_W{1'b0}}};
    min_pos  = '0;
  endfunction

  function automatic void integrate_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned   bc;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   len;
    int unsigned   k;
    longint        wsum;
    longint        charge;
    pulse_result_t r;
    bc = (int'(base_count) > WAVE_LEN) ? WAVE_LEN : int'(base_count);
    wave_mem[wave_pos] = s;
    if (int'(wave_pos) < bc) base_acc = base_acc + 23'(s);
    if ({1'b0, s} < min_val) begin
      min_val = {1'b0, s};
      min_pos = wave_pos;
    end
    if (int'(wave_pos) + 1 < WAVE_LEN) begin
      wave_pos = wave_pos + 1'b1;
      return;
    end
    lo = (min_pos >= pre_count) ? int'(min_pos - pre_count) : 0;
    hi = int'(min_pos) + int'(post_count);
    if (hi > WAVE_LEN) hi = WAVE_LEN;
    wsum = 0;
    for (k = lo; k < hi; k++) wsum += longint'(wave_mem[k]);
    len = hi - lo;
    charge = wsum * longint'(bc) - longint'(len) * longint'(base_acc);
    r.baseline_sum  = BASE_SUM_W'(base_acc);
    r.min_adc       = MIN_ADC_W'(min_val);
    r.min_index     = min_pos;
    r.window_sum    = WIN_SUM_W'(wsum);
    r.window_length = WIN_LEN_W'(len);
    r.charge_scaled = CHARGE_W'(charge);
    expected_pulses.insert(expected_pulses.size(), r);
    start_wave();
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      if (mismatches < 10)
        $display("pulse %0d %s: expected %0d, got %0d", pulses_seen, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_pulses.size() == 0) begin
        if (mismatches < 10) $display("pulse %0d: result with none expected", pulses_seen);
        mismatches++;
      end else begin
        check_field("baseline_sum", expected_pulses[0].baseline_sum, res_if.baseline_sum);
        check_field("min_adc", expected_pulses[0].min_adc, res_if.min_adc);
        check_field("min_index", expected_pulses[0].min_index, res_if.min_index);
        check_field("window_sum", expected_pulses[0].window_sum, res_if.window_sum);
        check_field("window_length", expected_pulses[0].window_length,
                    res_if.window_length);
        check_field("charge_scaled", expected_pulses[0].charge_scaled,
                    res_if.charge_scaled);
        void'(expected_pulses.pop_front());
      end
      pulses_seen++;
    end
  end

  // result side: a random stall after every result, or a long hold when asked
  initial begin
    int unsigned stall_left;
    res_if.ready = 1'b0;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) stall_left = $urandom_range(0, rx_max_gap);
      if (rx_hold > 0) begin
        stall_left = rx_hold;
        rx_hold = 0;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int unsigned gap);
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk); while (!smp_if.ready);
    integrate_sample(s);
  endtask

  task automatic send_shape(input int unsigned max_gap);
    int k;
    for (k = 0; k < WAVE_LEN; k++) send_sample(shape[k], $urandom_range(0, max_gap));
  endtask

  // stop sending and wait for every pending pulse, block idle afterwards
  task automatic settle();
    smp_if.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [BC_W-1:0] bc, input logic [PRE_W-1:0] pre,
                            input logic [POST_W-1:0] post);
    cfg_write <= 1'b1;
    cfg_index <= REG_BASELINE_COUNT;
    cfg_data  <= CFG_DATA_W'(bc);
    @(posedge clk);
    cfg_index <= REG_PRE_WINDOW;
    cfg_data  <= CFG_DATA_W'(pre);
    @(posedge clk);
    cfg_index <= REG_POST_WINDOW;
    cfg_data  <= CFG_DATA_W'(post);
    @(posedge clk);
    cfg_write <= 1'b0;
    base_count = bc;
    pre_count  = pre;
    post_count = post;
  endtask

  // triangular negative pulse on a flat baseline with optional noise
  function automatic void build_pulse(input int peak, input int depth, input int level,
                                      input int width, input int noise);
    int k;
    int d;
    int v;
    for (k = 0; k < WAVE_LEN; k++) begin
      d = (k > peak) ? k - peak : peak - k;
      v = level;
      if (noise > 0) v = v + int'($urandom_range(0, noise)) - noise / 2;
      if (d < width) v = v - depth * (width - d) / width;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      shape[k] = SAMPLE_W'(v);
    end
  endfunction

  function automatic void build_noise();
    int k;
    for (k = 0; k < WAVE_LEN; k++) shape[k] = SAMPLE_W'($urandom_range(0, 4095));
  endfunction

  function automatic void build_flat(input logic [SAMPLE_W-1:0] v);
    int k;
    for (k = 0; k < WAVE_LEN; k++) shape[k] = v;
  endfunction

  function automatic int unsigned draw_gap_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 17;
    endcase
  endfunction

  task automatic test_reset_defaults();
    build_pulse(300, 1500, 2048, 20, 0);
    send_shape(0);
  endtask

  task automatic test_sample_extremes();
    // peak at zero on a full-scale waveform, window clamped at the end
    build_flat(12'hfff);
    shape[700] = '0;
    send_shape(0);
    // all zero: every sample ties, first index wins and window clamps at 0
    build_flat('0);
    send_shape(3);
  endtask

  task automatic test_min_ties();
    build_flat(12'd2000);
    shape[400] = 12'd100;
    shape[900] = 12'd100;
    send_shape(0);
  endtask

  task automatic test_window_clamp();
    settle();
    set_config(11'd16, 10'd1023, 11'd2047);
    build_pulse(5, 2000, 3000, 4, 0);
    send_shape(0);
    settle();
    set_config(11'd16, 10'd0, 11'd1);
    build_flat(12'd3000);
    shape[WAVE_LEN-1] = 12'd10;
    send_shape(0);
    settle();
    // empty window
    set_config(11'd16, 10'd0, 11'd0);
    build_pulse(512, 1000, 2500, 8, 0);
    send_shape(0);
    settle();
    set_config(11'd100, 10'd1023, 11'd1024);
    build_pulse(1000, 1800, 2200, 10, 20);
    send_shape(0);
  endtask

  task automatic test_baseline_count();
    logic [BC_W-1:0] counts [4];
    int k;
    counts = '{11'd0, 11'd1, 11'd1024, 11'd2047};
    for (k = 0; k < 4; k++) begin
      settle();
      set_config(counts[k], 10'd64, 11'd576);
      build_pulse(600, 2000, 2500, 30, 30);
      send_shape(k == 3 ? 17 : 0);
    end
  endtask

  task automatic test_output_backpressure();
    int k;
    settle();
    set_config(11'd128, 10'd64, 11'd576);
    rx_max_gap = 0;
    rx_hold = 4000;
    for (k = 0; k < 3; k++) begin
      build_pulse($urandom_range(0, WAVE_LEN - 1), 1500, 2500, 40, 20);
      send_shape(0);
    end
  endtask

  task automatic test_random_pulses();
    int n;
    for (n = 0; n < 48; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        if ($urandom_range(0, 3) == 0)
          set_config(BC_W'($urandom_range(0, 2047)), PRE_W'($urandom_range(0, 1023)),
                     POST_W'($urandom_range(0, 2047)));
        else
          set_config(BC_W'($urandom_range(1, 1024)), PRE_W'($urandom_range(0, 1023)),
                     POST_W'($urandom_range(1, 1024)));
      end
      rx_max_gap = draw_gap_limit();
      if ($urandom_range(0, 4) == 0)
        build_noise();
      else
        build_pulse($urandom_range(0, WAVE_LEN - 1), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(1, 200),
                    $urandom_range(0, 40));
      send_shape(draw_gap_limit());
    end
  endtask

  initial begin
    cfg_write     = 1'b0;
    cfg_index     = REG_BASELINE_COUNT;
    cfg_data      = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    base_count    = BC_RESET;
    pre_count     = PRE_RESET;
    post_count    = POST_RESET;
    start_wave();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_sample_extremes();
    test_min_ties();
    test_window_clamp();
    test_baseline_count();
    test_output_backpressure();
    test_random_pulses();
    smp_if.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (mismatches == 0 && expected_pulses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pbpc_pkg.sv
rtl/pbpc_sample_if.sv
rtl/pbpc_result_if.sv
rtl/pbpc_ram.sv
rtl/pbpc_capture.sv
rtl/pbpc_window.sv
rtl/pulse_baseline_peak_charge.sv
tb/sv/tb_top.sv
